>>> hw/rtl/assert_macros.svh
// assertion macros shared by the rtl files
// clocked on clk_i and disabled while rst_ni is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

>>> hw/rtl/teh_pkg.sv
// shared types for the timed event heap scheduler
// command and status structs between controller and datapath; no dependencies
package teh_pkg;

  localparam int ID_W   = 4;
  localparam int TIME_W = 64;

  typedef enum logic [1:0] {
    ACT_RUN = 2'd0,
    ACT_ADD = 2'd1,
    ACT_DEL = 2'd2,
    ACT_NOP = 2'd3
  } act_e;

  typedef enum logic [2:0] {
    ST_FIRED     = 3'd0,
    ST_ADDED     = 3'd1,
    ST_DELETED   = 3'd2,
    ST_IGNORED   = 3'd3,
    ST_FULL      = 3'd4,
    ST_PER_DEL   = 3'd5,
    ST_SCHEDULED = 3'd6,
    ST_ZERO_PER  = 3'd7
  } status_e;

  // heap read address source
  typedef enum logic [2:0] {
    HA_ZERO   = 3'd0,
    HA_TAIL   = 3'd1,
    HA_LEFT   = 3'd2,
    HA_RIGHT  = 3'd3,
    HA_PARENT = 3'd4
  } hsel_e;

  // slot written into the hole
  typedef enum logic [1:0] {
    WS_CAND = 2'd0,
    WS_READ = 2'd1,
    WS_HOLE = 2'd2
  } wsel_e;

  // output word source
  typedef enum logic [1:0] {
    EM_SINGLE = 2'd0,
    EM_PEND   = 2'd1,
    EM_NONE   = 2'd2
  } esel_e;

  typedef struct packed {
    logic    load;
    logic    run_init;
    logic    add_init;
    logic    prd_en;
    logic    del_init;
    logic    hrd_en;
    hsel_e   hsel;
    logic    drd_en;
    logic    ld_x_slot;
    logic    ld_x_key;
    logic    dn_begin;
    logic    take_l;
    logic    take_r;
    logic    mv_we;
    wsel_e   wsel;
    logic    n_to_s;
    logic    n_to_p;
    logic    ld_head;
    logic    fire;
    logic    rearm;
    logic    remove;
    logic    emit;
    esel_e   esel;
    status_e code;
    logic    more;
    logic    last;
  } cmd_t;

  typedef struct packed {
    act_e act;
    logic ev_ok;
    logic sched;
    logic periodic;
    logic bad_period;
    logic full;
    logic cnt_zero;
    logic last_one;
    logic l_ok;
    logic r_ok;
    logic n_zero;
    logic found;
    logic at_start;
    logic key_le;
    logic head_due;
    logic cap;
    logic pend;
    logic idx_tail;
    logic out_free;
  } sts_t;

endpackage

>>> hw/rtl/timed_event_heap_scheduler.sv
// channel | handshake              | word
// in      | in_valid_i / in_stall_o | action, time_now, event_id, delay, periodic
// out     | out_valid_o / out_stall_i | fired_id, status, latency, more_due, last
//
// one item at a time; add, delete and each firing of a run are paced by the
// single read port of the heap and due-time memories (one heap level per
// sift iteration)
// a run gives one word per firing, at most MAX_FIRES, or one word if nothing is due
// rst_ni clears the event count and slot flags; no clearing pass is needed
// out_stall_i holds the sequencer only where it has a word to deliver
`include "assert_macros.svh"

module timed_event_heap_scheduler #(
  parameter int NUM_EVENTS = 16,
  parameter int MAX_FIRES  = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [1:0]                  action_i,
  input  logic [teh_pkg::TIME_W-1:0]  time_now_i,
  input  logic [teh_pkg::ID_W-1:0]    event_id_i,
  input  logic [teh_pkg::TIME_W-1:0]  delay_i,
  input  logic                        periodic_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [teh_pkg::ID_W-1:0]    fired_id_o,
  output logic [2:0]                  status_o,
  output logic [teh_pkg::TIME_W-1:0]  latency_o,
  output logic                        more_due_o,
  output logic                        last_o
);
  import teh_pkg::*;

  cmd_t cmd;
  sts_t sts;

  teh_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  teh_dpath #(
    .NUM_EVENTS (NUM_EVENTS),
    .MAX_FIRES  (MAX_FIRES)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .action_i    (action_i),
    .time_now_i  (time_now_i),
    .event_id_i  (event_id_i),
    .delay_i     (delay_i),
    .periodic_i  (periodic_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .fired_id_o  (fired_id_o),
    .status_o    (status_o),
    .latency_o   (latency_o),
    .more_due_o  (more_due_o),
    .last_o      (last_o)
  );

  `ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o)
  `ASSERT_IMPL(a_emit_needs_room, cmd.emit, sts.out_free)
  `ASSERT_IMPL(a_more_on_final_fire, out_valid_o && more_due_o, last_o && (status_o == ST_FIRED))
  `ASSERT_IMPL(a_single_word_final, out_valid_o && (status_o != ST_FIRED), last_o && (latency_o == '0))

endmodule

>>> hw/rtl/teh_dpath.sv
// datapath of the timed event heap scheduler: heap, due-time and position memories,
// per-slot flags, sift registers and the output register; uses teh_pkg
module teh_dpath #(
  parameter int NUM_EVENTS = 16,
  parameter int MAX_FIRES  = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [1:0]                  action_i,
  input  logic [teh_pkg::TIME_W-1:0]  time_now_i,
  input  logic [teh_pkg::ID_W-1:0]    event_id_i,
  input  logic [teh_pkg::TIME_W-1:0]  delay_i,
  input  logic                        periodic_i,
  input  teh_pkg::cmd_t               cmd_i,
  output teh_pkg::sts_t               sts_o,
  input  logic                        out_stall_i,
  output logic                        out_valid_o,
  output logic [teh_pkg::ID_W-1:0]    fired_id_o,
  output logic [2:0]                  status_o,
  output logic [teh_pkg::TIME_W-1:0]  latency_o,
  output logic                        more_due_o,
  output logic                        last_o
);
  import teh_pkg::*;

  // event_id is four bits wide, so no more than sixteen slots can ever be used
  localparam int SLOTS = (NUM_EVENTS < (1 << ID_W)) ? NUM_EVENTS : (1 << ID_W);
  localparam int PW    = $clog2(SLOTS);
  localparam int CW    = $clog2(SLOTS + 1);
  localparam int FW    = $clog2(MAX_FIRES + 1);
  localparam int IXW   = PW + 2;

  act_e              act_q;
  logic [TIME_W-1:0] now_q, dly_q;
  logic [ID_W-1:0]   ev_q;
  logic              per_q;

  logic [CW-1:0]     cnt_q;
  logic [PW-1:0]     n_q, start_q, s_q, ss_q, xs_q, hs_q, pid_q;
  logic [TIME_W-1:0] xk_q, sk_q, plat_q;
  logic              found_q, pend_q;
  logic [FW-1:0]     fires_q;

  logic [PW-1:0]     heap_mem [SLOTS];
  logic [TIME_W-1:0] due_mem  [SLOTS];
  logic [PW-1:0]     pos_mem  [SLOTS];
  logic [PW-1:0]     hrd_q, prd_q;
  logic [TIME_W-1:0] drd_q;

  logic [TIME_W-1:0] period_q [SLOTS];
  logic [SLOTS-1:0]  perd_q, sched_q;

  logic              out_valid_q;
  logic [ID_W-1:0]   out_id_q;
  status_e           out_st_q;
  logic [TIME_W-1:0] out_lat_q;
  logic              out_more_q, out_last_q;

  logic [IXW-1:0]    l_ix, r_ix;
  logic [PW-1:0]     nm1, p_ix, tail_ix, hrd_addr, sel_ix, ev_ix, wslot;
  logic [CW-1:0]     cnt_m1;
  logic              ev_ok, out_free, due_we;
  logic [TIME_W-1:0] sum_add, sum_rearm, lat, due_wdata;
  logic [PW-1:0]     due_waddr;
  logic              l_less, r_less;

  assign ev_ix   = ev_q[PW-1:0];
  assign l_ix    = {1'b0, n_q, 1'b1};
  assign r_ix    = l_ix + IXW'(1);
  assign nm1     = n_q - PW'(1);
  assign p_ix    = nm1 >> 1;
  assign cnt_m1  = cnt_q - CW'(1);
  assign tail_ix = cnt_m1[PW-1:0];
  assign ev_ok   = {1'b0, ev_q} < (ID_W + 1)'(SLOTS);
  assign sel_ix  = (act_q == ACT_RUN) ? hs_q : ev_ix;

  assign sum_add   = now_q + dly_q;
  assign sum_rearm = drd_q + period_q[sel_ix];
  assign lat       = now_q - drd_q;
  assign l_less    = drd_q < sk_q;
  assign r_less    = drd_q < sk_q;

  assign due_we    = cmd_i.add_init | cmd_i.rearm;
  assign due_waddr = cmd_i.add_init ? ev_ix : hs_q;
  assign due_wdata = cmd_i.add_init ? sum_add : sum_rearm;
  assign out_free  = !out_valid_q || !out_stall_i;

  always_comb begin
    case (cmd_i.hsel)
      HA_ZERO:   hrd_addr = '0;
      HA_TAIL:   hrd_addr = tail_ix;
      HA_LEFT:   hrd_addr = l_ix[PW-1:0];
      HA_RIGHT:  hrd_addr = r_ix[PW-1:0];
      HA_PARENT: hrd_addr = p_ix;
      default:   hrd_addr = '0;
    endcase
  end

  always_comb begin
    case (cmd_i.wsel)
      WS_CAND: wslot = ss_q;
      WS_READ: wslot = hrd_q;
      WS_HOLE: wslot = xs_q;
      default: wslot = xs_q;
    endcase
  end

  // memories, one read and one write port each, registered read data
  always_ff @(posedge clk_i) begin
    if (cmd_i.hrd_en) hrd_q <= heap_mem[hrd_addr];
    if (cmd_i.drd_en) drd_q <= due_mem[hrd_q];
    if (cmd_i.prd_en) prd_q <= pos_mem[ev_ix];
    if (cmd_i.mv_we) begin
      heap_mem[n_q]  <= wslot;
      pos_mem[wslot] <= n_q;
    end
    if (due_we) due_mem[due_waddr] <= due_wdata;
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q <= act_e'(action_i);
      now_q <= time_now_i;
      ev_q  <= event_id_i;
      dly_q <= delay_i;
      per_q <= periodic_i;
    end
    if (cmd_i.add_init && per_q) period_q[sel_ix] <= dly_q;
    if (cmd_i.add_init) begin
      n_q     <= cnt_q[PW-1:0];
      start_q <= cnt_q[PW-1:0];
      xs_q    <= ev_ix;
      xk_q    <= sum_add;
    end
    if (cmd_i.del_init) begin
      n_q     <= prd_q;
      start_q <= prd_q;
    end
    if (cmd_i.rearm) begin
      n_q     <= '0;
      start_q <= '0;
      xs_q    <= hs_q;
      xk_q    <= sum_rearm;
    end
    if (cmd_i.remove) begin
      n_q     <= '0;
      start_q <= '0;
    end
    if (cmd_i.ld_x_slot) xs_q <= hrd_q;
    if (cmd_i.ld_x_key)  xk_q <= drd_q;
    if (cmd_i.dn_begin) begin
      sk_q <= xk_q;
      s_q  <= n_q;
    end
    if (cmd_i.take_l && l_less) begin
      s_q  <= l_ix[PW-1:0];
      ss_q <= hrd_q;
      sk_q <= drd_q;
    end
    if (cmd_i.take_r && r_less) begin
      s_q  <= r_ix[PW-1:0];
      ss_q <= hrd_q;
      sk_q <= drd_q;
    end
    if (cmd_i.n_to_s) n_q <= s_q;
    if (cmd_i.n_to_p) n_q <= p_ix;
    if (cmd_i.ld_head) hs_q <= hrd_q;
    if (cmd_i.fire) begin
      pid_q  <= hs_q;
      plat_q <= lat;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      sched_q <= '0;
      perd_q  <= '0;
      found_q <= 1'b0;
      pend_q  <= 1'b0;
      fires_q <= '0;
    end else begin
      if (cmd_i.add_init) begin
        cnt_q           <= cnt_q + CW'(1);
        sched_q[sel_ix] <= 1'b1;
        perd_q[sel_ix]  <= per_q;
      end
      if (cmd_i.del_init || cmd_i.remove) begin
        cnt_q           <= cnt_m1;
        sched_q[sel_ix] <= 1'b0;
      end
      if (cmd_i.dn_begin) found_q <= 1'b0;
      if ((cmd_i.take_l && l_less) || (cmd_i.take_r && r_less)) found_q <= 1'b1;
      if (cmd_i.run_init) begin
        pend_q  <= 1'b0;
        fires_q <= '0;
      end
      if (cmd_i.fire) begin
        pend_q  <= 1'b1;
        fires_q <= fires_q + FW'(1);
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      case (cmd_i.esel)
        EM_SINGLE: begin
          out_id_q   <= (act_q == ACT_NOP) ? '0 : ev_q;
          out_st_q   <= cmd_i.code;
          out_lat_q  <= '0;
          out_more_q <= 1'b0;
          out_last_q <= 1'b1;
        end
        EM_PEND: begin
          out_id_q   <= ID_W'(pid_q);
          out_st_q   <= ST_FIRED;
          out_lat_q  <= plat_q;
          out_more_q <= cmd_i.more;
          out_last_q <= cmd_i.last;
        end
        default: begin
          out_id_q   <= '0;
          out_st_q   <= ST_IGNORED;
          out_lat_q  <= '0;
          out_more_q <= 1'b0;
          out_last_q <= 1'b1;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign fired_id_o  = out_id_q;
  assign status_o    = out_st_q;
  assign latency_o   = out_lat_q;
  assign more_due_o  = out_more_q;
  assign last_o      = out_last_q;

  always_comb begin
    sts_o.act        = act_q;
    sts_o.ev_ok      = ev_ok;
    sts_o.sched      = sched_q[sel_ix] && ((act_q == ACT_RUN) || ev_ok);
    sts_o.periodic   = perd_q[sel_ix] && ((act_q == ACT_RUN) || ev_ok);
    sts_o.bad_period = per_q && (dly_q == '0);
    sts_o.full       = cnt_q >= CW'(SLOTS);
    sts_o.cnt_zero   = cnt_q == '0;
    sts_o.last_one   = cnt_q == CW'(1);
    sts_o.l_ok       = l_ix < IXW'(cnt_q);
    sts_o.r_ok       = r_ix < IXW'(cnt_q);
    sts_o.n_zero     = n_q == '0;
    sts_o.found      = found_q;
    sts_o.at_start   = n_q == start_q;
    sts_o.key_le     = drd_q <= xk_q;
    sts_o.head_due   = (cnt_q != '0) && (drd_q <= now_q);
    sts_o.cap        = fires_q == FW'(MAX_FIRES);
    sts_o.pend       = pend_q;
    sts_o.idx_tail   = prd_q == tail_ix;
    sts_o.out_free   = out_free;
  end

endmodule

>>> hw/rtl/teh_ctrl.sv
// controller of the timed event heap scheduler: one-hot sequencer for
// add, delete, run and the sift loops; uses teh_pkg
module teh_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  teh_pkg::sts_t sts_i,
  output teh_pkg::cmd_t cmd_o
);
  import teh_pkg::*;

  typedef enum logic [19:0] {
    S_IDLE    = 20'h00001,
    S_DECODE  = 20'h00002,
    S_DEL_POS = 20'h00004,
    S_DEL_RDX = 20'h00008,
    S_DEL_RDK = 20'h00010,
    S_DN_L    = 20'h00020,
    S_DN_LS   = 20'h00040,
    S_DN_LK   = 20'h00080,
    S_DN_RS   = 20'h00100,
    S_DN_RK   = 20'h00200,
    S_DN_DEC  = 20'h00400,
    S_DN_END  = 20'h00800,
    S_UP_CHK  = 20'h01000,
    S_UP_RS   = 20'h02000,
    S_UP_PK   = 20'h04000,
    S_PLACE   = 20'h08000,
    S_FIN     = 20'h10000,
    S_RUN_RD0 = 20'h20000,
    S_RUN_RD1 = 20'h40000,
    S_RUN_CHK = 20'h80000
  } state_e;

  state_e  state_q, state_d;
  logic    err;
  status_e err_code;
  logic    go;

  assign in_stall_o = (state_q != S_IDLE);
  assign go         = sts_i.head_due && !sts_i.cap;

  always_comb begin
    err      = 1'b0;
    err_code = ST_IGNORED;
    case (sts_i.act)
      ACT_ADD: begin
        if (!sts_i.ev_ok) begin
          err = 1'b1;
        end else if (sts_i.sched) begin
          err = 1'b1; err_code = ST_SCHEDULED;
        end else if (sts_i.bad_period) begin
          err = 1'b1; err_code = ST_ZERO_PER;
        end else if (sts_i.full) begin
          err = 1'b1; err_code = ST_FULL;
        end
      end
      ACT_DEL: begin
        if (!sts_i.ev_ok || !sts_i.sched) begin
          err = 1'b1;
        end else if (sts_i.periodic) begin
          err = 1'b1; err_code = ST_PER_DEL;
        end
      end
      ACT_NOP: err = 1'b1;
      default: err = 1'b0;
    endcase
  end

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DECODE;
        end
      end
      S_DECODE: begin
        if (err) begin
          if (sts_i.out_free) begin
            cmd_o.emit = 1'b1;
            cmd_o.esel = EM_SINGLE;
            cmd_o.code = err_code;
            state_d    = S_IDLE;
          end
        end else if (sts_i.act == ACT_RUN) begin
          cmd_o.run_init = 1'b1;
          state_d        = S_RUN_RD0;
        end else if (sts_i.act == ACT_ADD) begin
          cmd_o.add_init = 1'b1;
          state_d        = S_UP_CHK;
        end else begin
          cmd_o.prd_en = 1'b1;
          state_d      = S_DEL_POS;
        end
      end
      S_DEL_POS: begin
        cmd_o.del_init = 1'b1;
        if (sts_i.idx_tail) begin
          state_d = S_FIN;
        end else begin
          cmd_o.hrd_en = 1'b1;
          cmd_o.hsel   = HA_TAIL;
          state_d      = S_DEL_RDX;
        end
      end
      S_DEL_RDX: begin
        cmd_o.ld_x_slot = 1'b1;
        cmd_o.drd_en    = 1'b1;
        state_d         = S_DEL_RDK;
      end
      S_DEL_RDK: begin
        cmd_o.ld_x_key = 1'b1;
        state_d        = S_DN_L;
      end
      S_DN_L: begin
        cmd_o.dn_begin = 1'b1;
        if (sts_i.l_ok) begin
          cmd_o.hrd_en = 1'b1;
          cmd_o.hsel   = HA_LEFT;
          state_d      = S_DN_LS;
        end else begin
          state_d = S_DN_END;
        end
      end
      S_DN_LS: begin
        cmd_o.drd_en = 1'b1;
        state_d      = S_DN_LK;
      end
      S_DN_LK: begin
        cmd_o.take_l = 1'b1;
        if (sts_i.r_ok) begin
          cmd_o.hrd_en = 1'b1;
          cmd_o.hsel   = HA_RIGHT;
          state_d      = S_DN_RS;
        end else begin
          state_d = S_DN_DEC;
        end
      end
      S_DN_RS: begin
        cmd_o.drd_en = 1'b1;
        state_d      = S_DN_RK;
      end
      S_DN_RK: begin
        cmd_o.take_r = 1'b1;
        state_d      = S_DN_DEC;
      end
      S_DN_DEC: begin
        if (sts_i.found) begin
          cmd_o.mv_we  = 1'b1;
          cmd_o.wsel   = WS_CAND;
          cmd_o.n_to_s = 1'b1;
          state_d      = S_DN_L;
        end else begin
          state_d = S_DN_END;
        end
      end
      // an entry that did not move down may still have to move up
      S_DN_END: state_d = sts_i.at_start ? S_UP_CHK : S_PLACE;
      S_UP_CHK: begin
        if (sts_i.n_zero) begin
          state_d = S_PLACE;
        end else begin
          cmd_o.hrd_en = 1'b1;
          cmd_o.hsel   = HA_PARENT;
          state_d      = S_UP_RS;
        end
      end
      S_UP_RS: begin
        cmd_o.drd_en = 1'b1;
        state_d      = S_UP_PK;
      end
      S_UP_PK: begin
        if (sts_i.key_le) begin
          state_d = S_PLACE;
        end else begin
          cmd_o.mv_we  = 1'b1;
          cmd_o.wsel   = WS_READ;
          cmd_o.n_to_p = 1'b1;
          state_d      = S_UP_CHK;
        end
      end
      S_PLACE: begin
        cmd_o.mv_we = 1'b1;
        cmd_o.wsel  = WS_HOLE;
        state_d     = (sts_i.act == ACT_RUN) ? S_RUN_RD0 : S_FIN;
      end
      S_FIN: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.esel = EM_SINGLE;
          cmd_o.code = (sts_i.act == ACT_ADD) ? ST_ADDED : ST_DELETED;
          state_d    = S_IDLE;
        end
      end
      S_RUN_RD0: begin
        if (sts_i.cnt_zero) begin
          state_d = S_RUN_CHK;
        end else begin
          cmd_o.hrd_en = 1'b1;
          cmd_o.hsel   = HA_ZERO;
          state_d      = S_RUN_RD1;
        end
      end
      S_RUN_RD1: begin
        cmd_o.ld_head = 1'b1;
        cmd_o.drd_en  = 1'b1;
        state_d       = S_RUN_CHK;
      end
      S_RUN_CHK: begin
        if (go) begin
          // the previous firing goes out once it is known not to be the final word
          if (!sts_i.pend || sts_i.out_free) begin
            cmd_o.emit = sts_i.pend;
            cmd_o.esel = EM_PEND;
            cmd_o.fire = 1'b1;
            if (sts_i.periodic) begin
              cmd_o.rearm = 1'b1;
              state_d     = S_DN_L;
            end else begin
              cmd_o.remove = 1'b1;
              if (sts_i.last_one) begin
                state_d = S_RUN_RD0;
              end else begin
                cmd_o.hrd_en = 1'b1;
                cmd_o.hsel   = HA_TAIL;
                state_d      = S_DEL_RDX;
              end
            end
          end
        end else if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.esel = sts_i.pend ? EM_PEND : EM_NONE;
          cmd_o.more = sts_i.head_due;
          cmd_o.last = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> bench/tb_top.sv
// testbench for the timed event heap scheduler: a queue driver, a result monitor
// and an in-bench heap predictor; needs teh_pkg and timed_event_heap_scheduler
module tb_top;
  import teh_pkg::*;

  localparam int NEV       = 16;
  localparam int FIRE_CAP  = 64;
  localparam int N_RANDOM  = 110;
  localparam int CYC_LIMIT = 2000000;

  typedef struct {
    act_e        act;
    logic [63:0] now;
    logic [3:0]  id;
    logic [63:0] dly;
    logic        per;
  } cmd_word_t;

  typedef struct {
    logic [3:0]  id;
    status_e     st;
    logic [63:0] lat;
    logic        more;
    logic        last;
  } sched_word_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  action_i = '0;
  logic [63:0] time_now_i = '0;
  logic [3:0]  event_id_i = '0;
  logic [63:0] delay_i = '0;
  logic        periodic_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [3:0]  fired_id_o;
  logic [2:0]  status_o;
  logic [63:0] latency_o;
  logic        more_due_o;
  logic        last_o;

  timed_event_heap_scheduler i_dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor copy of the heap and the slot table
  logic [3:0]  heap_q [NEV];
  int          heap_n;
  logic [63:0] due_at [NEV];
  logic [63:0] period [NEV];
  bit          rearms [NEV];
  bit          armed  [NEV];
  int          node_of [NEV];

  cmd_word_t   cmd_q[$];
  sched_word_t due_words[$];
  int          errors = 0;
  int          cycles = 0;
  int          popped = 0;
  int          n_total = 1;
  bit          taken = 0;

  task automatic swap_nodes(int a, int b);
    logic [3:0] t;
    t = heap_q[a];
    heap_q[a] = heap_q[b];
    heap_q[b] = t;
    node_of[heap_q[a]] = a;
    node_of[heap_q[b]] = b;
  endtask

  task automatic sift_up(int n);
    int p;
    while (n > 0) begin
      p = (n - 1) / 2;
      if (due_at[heap_q[p]] <= due_at[heap_q[n]]) break;
      swap_nodes(p, n);
      n = p;
    end
  endtask

  task automatic sink_node(int n);
    int s, l, r;
    while (n < heap_n) begin
      s = n;
      l = 2 * n + 1;
      r = l + 1;
      if (l < heap_n && due_at[heap_q[l]] < due_at[heap_q[s]]) s = l;
      if (r < heap_n && due_at[heap_q[r]] < due_at[heap_q[s]]) s = r;
      if (s == n) break;
      swap_nodes(n, s);
      n = s;
    end
  endtask

  task automatic drop_slot(int ev);
    int idx;
    idx = node_of[ev];
    if (heap_n == 0) return;
    heap_n--;
    armed[ev] = 0;
    if (idx != heap_n) begin
      heap_q[idx] = heap_q[heap_n];
      node_of[heap_q[idx]] = idx;
      sink_node(idx);
      sift_up(idx);
    end
  endtask

  task automatic push_word(logic [3:0] id, status_e st, logic [63:0] lat);
    sched_word_t w;
    w.id = id; w.st = st; w.lat = lat; w.more = 1'b0; w.last = 1'b1;
    due_words.push_back(w);
  endtask

  task automatic predict_schedule(cmd_word_t c);
    int k;
    int ev;
    k = 0;
    ev = int'(c.id);
    case (c.act)
      ACT_RUN: begin
        while (k < FIRE_CAP && heap_n > 0 && due_at[heap_q[0]] <= c.now) begin
          ev = int'(heap_q[0]);
          push_word(4'(ev), ST_FIRED, c.now - due_at[ev]);
          due_words[due_words.size()-1].last = 1'b0;
          if (rearms[ev]) begin
            due_at[ev] += period[ev];
            sink_node(node_of[ev]);
          end else begin
            drop_slot(ev);
          end
          k++;
        end
        if (k == 0) begin
          push_word(4'd0, ST_IGNORED, 64'd0);
        end else begin
          due_words[due_words.size()-1].last = 1'b1;
          if (heap_n > 0 && due_at[heap_q[0]] <= c.now)
            due_words[due_words.size()-1].more = 1'b1;
        end
      end
      ACT_ADD: begin
        if (armed[ev]) push_word(4'(ev), ST_SCHEDULED, 64'd0);
        else if (c.per && c.dly == 0) push_word(4'(ev), ST_ZERO_PER, 64'd0);
        else if (heap_n >= NEV) push_word(4'(ev), ST_FULL, 64'd0);
        else begin
          node_of[ev] = heap_n;
          armed[ev] = 1;
          rearms[ev] = c.per;
          if (c.per) period[ev] = c.dly;
          due_at[ev] = c.now + c.dly;
          heap_q[heap_n] = 4'(ev);
          heap_n++;
          sift_up(heap_n - 1);
          push_word(4'(ev), ST_ADDED, 64'd0);
        end
      end
      ACT_DEL: begin
        if (!armed[ev]) push_word(4'(ev), ST_IGNORED, 64'd0);
        else if (rearms[ev]) push_word(4'(ev), ST_PER_DEL, 64'd0);
        else begin
          drop_slot(ev);
          push_word(4'(ev), ST_DELETED, 64'd0);
        end
      end
      default: push_word(4'd0, ST_IGNORED, 64'd0);
    endcase
  endtask

  function automatic cmd_word_t mk(act_e a, logic [63:0] now, int id,
                                   logic [63:0] dly, logic per);
    cmd_word_t c;
    c.act = a; c.now = now; c.id = 4'(id); c.dly = dly; c.per = per;
    return c;
  endfunction

  function automatic int phase_now();
    return (popped * 4) / n_total;
  endfunction

  // accept on the rising edge, predict in acceptance order
  always @(posedge clk_i) begin
    cycles++;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      predict_schedule(mk(act_e'(action_i), time_now_i, event_id_i, delay_i, periodic_i));
      taken = 1;
    end
    if (cycles > CYC_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // driver: new word on the falling edge
  always @(negedge clk_i) begin
    int ph;
    cmd_word_t c;
    ph = phase_now();
    if (rst_ni) begin
      if (!in_valid_i || taken) begin
        taken = 0;
        if (cmd_q.size() > 0 &&
            !((ph == 1 && $urandom_range(99) < 71) || (ph == 3 && $urandom_range(99) < 18))) begin
          c = cmd_q.pop_front();
          popped++;
          in_valid_i <= 1'b1;
          action_i   <= c.act;
          time_now_i <= c.now;
          event_id_i <= c.id;
          delay_i    <= c.dly;
          periodic_i <= c.per;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_stall_i <= (ph == 2 && $urandom_range(99) < 71) ||
                     (ph == 3 && $urandom_range(99) < 18);
    end
  end

  // monitor
  always @(posedge clk_i) begin
    sched_word_t w;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (due_words.size() == 0) begin
        $error("unexpected word: fired_id %0d status %0d", fired_id_o, status_o);
        errors++;
      end else begin
        w = due_words.pop_front();
        if (fired_id_o !== w.id) begin
          $error("fired_id expected %0d actual %0d", w.id, fired_id_o); errors++;
        end
        if (status_o !== w.st) begin
          $error("status expected %0d actual %0d", w.st, status_o); errors++;
        end
        if (latency_o !== w.lat) begin
          $error("latency expected %0d actual %0d", w.lat, latency_o); errors++;
        end
        if (more_due_o !== w.more) begin
          $error("more_due expected %0d actual %0d", w.more, more_due_o); errors++;
        end
        if (last_o !== w.last) begin
          $error("last expected %0d actual %0d", w.last, last_o); errors++;
        end
      end
    end
  end

  initial begin
    logic [63:0] t;
    logic [63:0] now, dly;
    int r;
    heap_n = 0;
    for (int i = 0; i < NEV; i++) begin
      due_at[i] = '0; period[i] = '0; rearms[i] = 0; armed[i] = 0; node_of[i] = 0;
    end
    // directed: errors, a full table, the firing cap and due-time wrap
    cmd_q.push_back(mk(ACT_RUN, 0, 0, 0, 0));
    cmd_q.push_back(mk(ACT_NOP, 0, 5, 7, 1));
    cmd_q.push_back(mk(ACT_ADD, 0, 0, 0, 1));
    cmd_q.push_back(mk(ACT_ADD, 0, 0, 1, 1));
    cmd_q.push_back(mk(ACT_ADD, 0, 0, 9, 0));
    cmd_q.push_back(mk(ACT_DEL, 0, 0, 0, 0));
    cmd_q.push_back(mk(ACT_DEL, 0, 1, 0, 0));
    for (int i = 1; i < NEV; i++)
      cmd_q.push_back(mk(ACT_ADD, 0, i, 400 - (i / 3) * 20, i[0]));
    cmd_q.push_back(mk(ACT_RUN, 100, 0, 0, 0));
    cmd_q.push_back(mk(ACT_DEL, 100, 2, 0, 0));
    cmd_q.push_back(mk(ACT_ADD, 200, 2, 64'hFFFF_FFFF_FFFF_FFFF, 0));
    cmd_q.push_back(mk(ACT_RUN, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0, 0));
    t = 64'd300;
    for (int n = 0; n < N_RANDOM; n++) begin
      t += $urandom_range(0, 20);
      now = t;
      if ($urandom_range(24) == 0) now = {$urandom, $urandom};
      r = $urandom_range(99);
      case ($urandom_range(9))
        0:       dly = 0;
        1:       dly = {$urandom, $urandom};
        default: dly = $urandom_range(1, 40);
      endcase
      cmd_q.push_back(mk(r < 35 ? ACT_RUN : r < 75 ? ACT_ADD : r < 95 ? ACT_DEL : ACT_NOP,
                         now, $urandom_range(15), dly, $urandom_range(1)));
    end
    n_total = cmd_q.size();
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    wait (cmd_q.size() == 0 && !in_valid_i);
    wait (due_words.size() == 0);
    repeat (400) @(posedge clk_i);
    if (errors == 0 && due_words.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/teh_pkg.sv
hw/rtl/teh_dpath.sv
hw/rtl/teh_ctrl.sv
hw/rtl/timed_event_heap_scheduler.sv
bench/tb_top.sv
